[sv/wpbt_pkg.sv]
// Shared types and constants for the weighted pair bond tally.
package wpbt_pkg;

  localparam int CONF_W     = 8;
  localparam int CONF_SPAN  = 256;
  localparam int CNT_W      = 32;
  localparam int FRAC_W     = 17;
  localparam int WEIGHT_W   = 24;
  localparam int THR_W      = 20;
  localparam int NRES_W     = 4;
  localparam int RES_W      = 3;
  localparam int MULT_W     = CNT_W + THR_W;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 88;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int QDEPTH     = 4;

  localparam logic [THR_W-1:0]  PPM_SCALE = 20'd1000000;
  localparam logic [CNT_W-1:0]  SAT32     = 32'hFFFF_FFFF;
  localparam logic [NRES_W-1:0] ACT_RESET = 4'd8;
  localparam logic [THR_W-1:0]  THR_RESET = 20'd1000;

  // input item kinds carried in tuser
  localparam logic [1:0] MODE_BOND   = 2'd0;
  localparam logic [1:0] MODE_SLOT   = 2'd1;
  localparam logic [1:0] MODE_REPORT = 2'd2;

  // register select, paddr bit 2
  localparam logic REG_ACTIVE = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  typedef enum logic [1:0] {
    CMD_BOND,
    CMD_SLOT,
    CMD_REPORT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [CONF_W-1:0]   row;
    logic [CONF_W-1:0]   col;
    logic                bond_bit;
    logic                slot_wr;
    logic [RES_W-1:0]    slot;
    logic [CONF_W-1:0]   slot_conf;
    logic                close;
    logic [WEIGHT_W-1:0] weight;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_beat_t;

endpackage

[sv/weighted_pair_bond_tally.sv]
// Bond and slot commands write their stores as they leave the queue; a record close walks
// all n*n pair cells, then drains. Report: one result per ordered pair (n*(n-1) pairs),
// each set by the 17-step serial divider and passed out through the output register.
// A 4-entry command queue lets input keep flowing while the back end works.
// Reset (sync, active low): counts, total, queue and config return to defaults;
// bond matrix and slot conformers hold garbage until written.
module weighted_pair_bond_tally #(
  parameter int NUM_CONFS    = 256,
  parameter int MAX_RESIDUES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [wpbt_pkg::IN_DATA_W-1:0]    in_tdata,  // row_conf[7:0], col_conf[15:8],
                                                       // bond_bit[16], slot[19:17],
                                                       // slot_conf[27:20],
                                                       // record_weight[51:28], zero pad
  input  logic [1:0]                        in_tuser,  // mode
  input  logic                              in_tlast,  // record_end
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [wpbt_pkg::OUT_DATA_W-1:0]   out_tdata, // from_residue[2:0], to_residue[5:3],
                                                       // weighted_count[37:6],
                                                       // fraction_q16[54:38],
                                                       // above_threshold[55],
                                                       // total_weight[87:56]
  output logic                              out_tlast, // last
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [wpbt_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [wpbt_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [wpbt_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  logic [wpbt_pkg::NRES_W-1:0] active_r;
  logic [wpbt_pkg::THR_W-1:0]  thresh_r;
  logic [wpbt_pkg::NRES_W-1:0] n_active;
  logic                        cfg_wr;
  wpbt_pkg::cmd_beat_t         q_push;
  wpbt_pkg::cmd_beat_t         q_head;
  logic                        q_pop;
  logic                        q_full;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= wpbt_pkg::ACT_RESET;
      thresh_r <= wpbt_pkg::THR_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == wpbt_pkg::REG_ACTIVE) begin
        active_r <= cfg_pwdata[wpbt_pkg::NRES_W-1:0];
      end else begin
        thresh_r <= cfg_pwdata[wpbt_pkg::THR_W-1:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == wpbt_pkg::REG_THRESH)
                    ? {{(wpbt_pkg::CFG_DATA_W - wpbt_pkg::THR_W){1'b0}}, thresh_r}
                    : {{(wpbt_pkg::CFG_DATA_W - wpbt_pkg::NRES_W){1'b0}}, active_r};

  // slot count clamped to 2..MAX_RESIDUES
  always_comb begin
    if (active_r < 4'd2) begin
      n_active = 4'd2;
    end else if (active_r > wpbt_pkg::NRES_W'(MAX_RESIDUES)) begin
      n_active = wpbt_pkg::NRES_W'(MAX_RESIDUES);
    end else begin
      n_active = active_r;
    end
  end

  wpbt_front #(
    .NUM_CONFS (NUM_CONFS)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .n_active  (n_active),
    .q_full    (q_full),
    .push      (q_push)
  );

  wpbt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .pop   (q_pop),
    .head  (q_head),
    .full  (q_full)
  );

  wpbt_back #(
    .NUM_CONFS    (NUM_CONFS),
    .MAX_RESIDUES (MAX_RESIDUES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .pop        (q_pop),
    .n_active   (n_active),
    .threshold  (thresh_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.valid |-> !q_full)
    else $error("command pushed into a full queue");

  a_count_within_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[37:6] <= out_tdata[87:56]))
    else $error("pair count exceeds grand total");

  a_zero_total_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[87:56] == 32'd0)) |-> (out_tdata[54:38] == 17'd0)
                                                    && !out_tdata[55])
    else $error("nonzero fraction or flag with zero total");

  a_fraction_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[54:38] <= 17'd65536))
    else $error("fraction above one");

endmodule

[sv/wpbt_front.sv]
// Input side: unpacks stream transactions, filters no-op items, builds commands.
module wpbt_front #(
  parameter int NUM_CONFS = 256
) (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [wpbt_pkg::IN_DATA_W-1:0] in_tdata,  // row_conf, col_conf, bond_bit, slot,
                                                    // slot_conf, record_weight, pad
  input  logic [1:0]                     in_tuser,  // mode
  input  logic                           in_tlast,  // record_end
  input  logic [wpbt_pkg::NRES_W-1:0]    n_active,
  input  logic                           q_full,
  output wpbt_pkg::cmd_beat_t            push
);

  logic [wpbt_pkg::CONF_W-1:0]   row;
  logic [wpbt_pkg::CONF_W-1:0]   col;
  logic                          bond_bit;
  logic [wpbt_pkg::RES_W-1:0]    slot;
  logic [wpbt_pkg::CONF_W-1:0]   slot_conf;
  logic [wpbt_pkg::WEIGHT_W-1:0] weight;
  logic                          slot_wr;
  logic                          keep;
  wpbt_pkg::cmd_kind_t           kind;

  always_comb begin
    row       = in_tdata[7:0];
    col       = in_tdata[15:8];
    bond_bit  = in_tdata[16];
    slot      = in_tdata[19:17];
    slot_conf = in_tdata[27:20];
    weight    = in_tdata[51:28];
    slot_wr   = ({1'b0, slot} < n_active);
    kind      = wpbt_pkg::CMD_REPORT;
    keep      = 1'b0;
    case (in_tuser)
      wpbt_pkg::MODE_BOND: begin
        kind = wpbt_pkg::CMD_BOND;
        keep = (32'(row) < 32'(NUM_CONFS)) && (32'(col) < 32'(NUM_CONFS));
      end
      wpbt_pkg::MODE_SLOT: begin
        kind = wpbt_pkg::CMD_SLOT;
        keep = slot_wr || in_tlast;
      end
      wpbt_pkg::MODE_REPORT: begin
        kind = wpbt_pkg::CMD_REPORT;
        keep = 1'b1;
      end
      default: begin
        kind = wpbt_pkg::CMD_REPORT;
        keep = 1'b0;
      end
    endcase
  end

  assign in_tready = !q_full;

  always_comb begin
    push.valid         = in_tvalid && !q_full && keep;
    push.cmd.kind      = kind;
    push.cmd.row       = row;
    push.cmd.col       = col;
    push.cmd.bond_bit  = bond_bit;
    push.cmd.slot_wr   = slot_wr;
    push.cmd.slot      = slot;
    push.cmd.slot_conf = slot_conf;
    push.cmd.close     = in_tlast;
    push.cmd.weight    = weight;
  end

endmodule

[sv/wpbt_queue.sv]
// Small command FIFO between the front and the back.
module wpbt_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  wpbt_pkg::cmd_beat_t push,
  input  logic                pop,
  output wpbt_pkg::cmd_beat_t head,
  output logic                full
);

  localparam int PTR_W = $clog2(wpbt_pkg::QDEPTH);
  localparam int CNT_W = $clog2(wpbt_pkg::QDEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(wpbt_pkg::QDEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(wpbt_pkg::QDEPTH);

  wpbt_pkg::cmd_t   mem_r [wpbt_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign do_push = push.valid && !full;
  assign do_pop  = pop && (cnt_r != '0);

  always_comb begin
    head.valid = (cnt_r != '0);
    head.cmd   = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

[sv/wpbt_back.sv]
// Execution side: bond and slot stores, pair count walk, report divider, output register.
module wpbt_back #(
  parameter int NUM_CONFS    = 256,
  parameter int MAX_RESIDUES = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wpbt_pkg::cmd_beat_t             head,
  output logic                            pop,
  input  logic [wpbt_pkg::NRES_W-1:0]     n_active,
  input  logic [wpbt_pkg::THR_W-1:0]      threshold,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [wpbt_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast
);

  localparam int RIW        = $clog2(MAX_RESIDUES);
  localparam int PAIR_AW    = 2 * RIW;
  localparam int PAIR_DEPTH = 1 << PAIR_AW;
  localparam int CONF_ROWS  = (NUM_CONFS < wpbt_pkg::CONF_SPAN) ? NUM_CONFS
                                                                 : wpbt_pkg::CONF_SPAN;
  localparam int ROW_W      = $clog2(CONF_ROWS);
  localparam int BOND_AW    = ROW_W + wpbt_pkg::CONF_W;
  localparam int BOND_DEPTH = CONF_ROWS * wpbt_pkg::CONF_SPAN;
  localparam int STEP_W     = $clog2(wpbt_pkg::FRAC_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(wpbt_pkg::FRAC_W - 1);

  localparam int CW = wpbt_pkg::CNT_W;
  localparam int FW = wpbt_pkg::FRAC_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLOSE,
    S_DRAIN,
    R_READ,
    R_LOAD,
    R_DIV,
    R_EMIT
  } state_t;

  state_t state_r;

  // stores
  logic                        bond_mem  [BOND_DEPTH];
  logic [wpbt_pkg::CONF_W-1:0] slot_mem  [MAX_RESIDUES];
  logic [CW-1:0]               pair_mem  [PAIR_DEPTH];
  logic [PAIR_DEPTH-1:0]       pvalid_r;

  // walk counters and close pipeline
  logic [RIW-1:0]                ci_r, cj_r;
  logic [wpbt_pkg::WEIGHT_W-1:0] w_r;
  logic [CW-1:0]                 total_r;
  logic                          s1_v_r, s1_go_r;
  logic [PAIR_AW-1:0]            s1_addr_r;
  logic                          s2_v_r, s2_go_r;
  logic [PAIR_AW-1:0]            s2_addr_r;
  logic [wpbt_pkg::CONF_W-1:0]   sa_q_r, sb_q_r;
  logic                          bond_q_r;
  logic                          inrange_q_r;
  logic [CW-1:0]                 pcnt_q_r;
  logic                          pvld_q_r;

  // report datapath
  logic [CW-1:0]               cnt_r;
  logic [wpbt_pkg::MULT_W-1:0] mc_r, mt_r;
  logic [CW-1:0]               rem_r;
  logic [FW-1:0]               dd_r;
  logic [FW-1:0]               quo_r;
  logic [STEP_W-1:0]           step_r;

  // output register
  logic                     out_valid_r;
  logic                     out_last_r;
  logic [wpbt_pkg::RES_W-1:0] out_from_r, out_to_r;
  logic [CW-1:0]            out_cnt_r, out_total_r;
  logic [FW-1:0]            out_frac_r;
  logic                     out_above_r;

  // combinational helpers
  logic [RIW-1:0]      n_last;
  logic [RIW-1:0]      ci_adv, cj_adv;
  logic                at_end;
  logic                is_last_pair;
  logic                out_free;
  logic                emit;
  logic [CW-1:0]       cnt_sel;
  logic [CW:0]         trial;
  logic [CW:0]         diff;
  logic                ge;
  logic [CW:0]         tot_sum;
  logic [CW-1:0]       tot_next;
  logic [CW:0]         pw_sum;
  logic [CW-1:0]       pw_data;
  logic                pw_en;
  logic                inrange;
  logic [BOND_AW-1:0]  bond_raddr;
  logic [BOND_AW-1:0]  bond_waddr;
  logic                bond_we;
  logic                slot_we;
  logic [PAIR_AW-1:0]  pr_addr;

  always_comb begin
    pop          = head.valid && (state_r == S_IDLE);
    n_last       = RIW'(n_active - 4'd1);
    at_end       = (ci_r == n_last) && (cj_r == n_last);
    is_last_pair = (ci_r == n_last) && (cj_r == RIW'(n_last - 1'b1));
    if (cj_r == n_last) begin
      cj_adv = '0;
      ci_adv = ci_r + 1'b1;
    end else begin
      cj_adv = cj_r + 1'b1;
      ci_adv = ci_r;
    end
    out_free = !out_valid_r || out_tready;
    emit     = (state_r == R_EMIT) && out_free;
    cnt_sel  = pvld_q_r ? pcnt_q_r : '0;

    // one restoring division step
    trial = {rem_r, dd_r[FW-1]};
    ge    = (trial >= {1'b0, total_r});
    diff  = trial - {1'b0, total_r};

    tot_sum  = {1'b0, total_r} + {{(CW + 1 - wpbt_pkg::WEIGHT_W){1'b0}}, head.cmd.weight};
    tot_next = tot_sum[CW] ? wpbt_pkg::SAT32 : tot_sum[CW-1:0];

    pw_sum  = {1'b0, cnt_sel} + {{(CW + 1 - wpbt_pkg::WEIGHT_W){1'b0}}, w_r};
    pw_data = pw_sum[CW] ? wpbt_pkg::SAT32 : pw_sum[CW-1:0];
    pw_en   = s2_v_r && s2_go_r && bond_q_r && inrange_q_r;

    inrange    = (32'(sa_q_r) < 32'(NUM_CONFS)) && (32'(sb_q_r) < 32'(NUM_CONFS));
    bond_raddr = inrange ? {sa_q_r[ROW_W-1:0], sb_q_r} : '0;
    bond_waddr = {head.cmd.row[ROW_W-1:0], head.cmd.col};
    bond_we    = pop && (head.cmd.kind == wpbt_pkg::CMD_BOND);
    slot_we    = pop && (head.cmd.kind == wpbt_pkg::CMD_SLOT) && head.cmd.slot_wr;
    pr_addr    = (state_r == R_READ) ? {ci_r, cj_r} : s1_addr_r;
  end

  always_ff @(posedge clk) begin
    if (bond_we) begin
      bond_mem[bond_waddr] <= head.cmd.bond_bit;
    end
    bond_q_r <= bond_mem[bond_raddr];
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[head.cmd.slot[RIW-1:0]] <= head.cmd.slot_conf;
    end
    sa_q_r <= slot_mem[ci_r];
    sb_q_r <= slot_mem[cj_r];
  end

  always_ff @(posedge clk) begin
    if (pw_en) begin
      pair_mem[s2_addr_r] <= pw_data;
    end
    pcnt_q_r <= pair_mem[pr_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      pvalid_r    <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pvld_q_r    <= pvalid_r[pr_addr];
      if (pw_en) begin
        pvalid_r[s2_addr_r] <= 1'b1;
      end
      s1_v_r      <= (state_r == S_CLOSE);
      s1_go_r     <= (ci_r != cj_r);
      s1_addr_r   <= {ci_r, cj_r};
      s2_v_r      <= s1_v_r;
      s2_go_r     <= s1_go_r;
      s2_addr_r   <= s1_addr_r;
      inrange_q_r <= inrange;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          ci_r <= '0;
          cj_r <= '0;
          if (pop) begin
            if (head.cmd.kind == wpbt_pkg::CMD_SLOT && head.cmd.close) begin
              w_r     <= head.cmd.weight;
              total_r <= tot_next;
              state_r <= S_CLOSE;
            end else if (head.cmd.kind == wpbt_pkg::CMD_REPORT) begin
              state_r <= R_READ;
            end
          end
        end
        S_CLOSE: begin
          ci_r <= ci_adv;
          cj_r <= cj_adv;
          if (at_end) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!s1_v_r && !s2_v_r) begin
            state_r <= S_IDLE;
          end
        end
        R_READ: begin
          // diagonal cells are skipped with a bubble
          if (ci_r == cj_r) begin
            ci_r <= ci_adv;
            cj_r <= cj_adv;
          end else begin
            state_r <= R_LOAD;
          end
        end
        R_LOAD: begin
          cnt_r   <= cnt_sel;
          mc_r    <= wpbt_pkg::MULT_W'(cnt_sel) * wpbt_pkg::MULT_W'(wpbt_pkg::PPM_SCALE);
          mt_r    <= wpbt_pkg::MULT_W'(total_r) * wpbt_pkg::MULT_W'(threshold);
          rem_r   <= {1'b0, cnt_sel[CW-1:1]};
          dd_r    <= {cnt_sel[0], {(FW - 1){1'b0}}};
          quo_r   <= '0;
          step_r  <= '0;
          state_r <= R_DIV;
        end
        R_DIV: begin
          rem_r  <= ge ? diff[CW-1:0] : trial[CW-1:0];
          dd_r   <= {dd_r[FW-2:0], 1'b0};
          quo_r  <= {quo_r[FW-2:0], ge};
          step_r <= step_r + 1'b1;
          if (step_r == STEP_LAST) begin
            state_r <= R_EMIT;
          end
        end
        R_EMIT: begin
          if (emit) begin
            out_last_r  <= is_last_pair;
            out_from_r  <= wpbt_pkg::RES_W'(ci_r);
            out_to_r    <= wpbt_pkg::RES_W'(cj_r);
            out_cnt_r   <= cnt_r;
            out_total_r <= total_r;
            out_frac_r  <= (total_r == '0) ? '0 : quo_r;
            out_above_r <= (total_r != '0) && (mc_r >= mt_r);
            ci_r        <= ci_adv;
            cj_r        <= cj_adv;
            state_r     <= is_last_pair ? S_IDLE : R_READ;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {out_total_r, out_above_r, out_frac_r, out_cnt_r, out_to_r, out_from_r};

endmodule

[test/tb_weighted_pair_bond_tally.sv]
// Self-checking stream testbench for the weighted pair bond tally block.
module tb_weighted_pair_bond_tally;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [wpbt_pkg::CFG_ADDR_W-1:0] ADDR_ACTIVE = {wpbt_pkg::REG_ACTIVE, 2'b00};
  localparam logic [wpbt_pkg::CFG_ADDR_W-1:0] ADDR_THRESH = {wpbt_pkg::REG_THRESH, 2'b00};
  localparam int SETTLE_CYCLES = 500;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int SAT_RECORDS = 270;
  localparam int RANDOM_ITEMS = 37;
  localparam logic [wpbt_pkg::CONF_W-1:0] CONF_POOL [6] =
    '{8'd0, 8'd1, 8'd2, 8'd127, 8'd128, 8'd255};

  typedef struct {
    logic [1:0]                    mode;
    logic [wpbt_pkg::CONF_W-1:0]   row;
    logic [wpbt_pkg::CONF_W-1:0]   col;
    logic                          bond;
    logic [wpbt_pkg::RES_W-1:0]    slot;
    logic [wpbt_pkg::CONF_W-1:0]   sconf;
    logic [wpbt_pkg::WEIGHT_W-1:0] weight;
    logic                          rend;
  } tally_item_t;

  typedef struct {
    logic [wpbt_pkg::RES_W-1:0]  from_res;
    logic [wpbt_pkg::RES_W-1:0]  to_res;
    logic [wpbt_pkg::CNT_W-1:0]  count;
    logic [wpbt_pkg::FRAC_W-1:0] frac;
    logic                        flag;
    logic [wpbt_pkg::CNT_W-1:0]  total;
    logic                        last;
  } pair_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [wpbt_pkg::IN_DATA_W-1:0] in_tdata = '0;  // row_conf, col_conf, bond_bit, slot,
                                                  // slot_conf, record_weight, zero pad
  logic [1:0] in_tuser = '0;                      // mode
  logic in_tlast = 1'b0;                          // record_end
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [wpbt_pkg::OUT_DATA_W-1:0] out_tdata;     // from_residue, to_residue,
                                                  // weighted_count, fraction_q16,
                                                  // above_threshold, total_weight
  logic out_tlast;                                // last
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [wpbt_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [wpbt_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [wpbt_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  weighted_pair_bond_tally dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // stimulus and expectation stores
  tally_item_t  tally_items[$];
  pair_result_t pair_reports[$];
  tally_item_t  drv_item;
  pair_result_t want;
  int queued = 0;
  int accepted = 0;
  int mismatches = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;

  // shadow of the block state
  logic [wpbt_pkg::NRES_W-1:0] act_reg = wpbt_pkg::ACT_RESET;
  logic [wpbt_pkg::THR_W-1:0]  thr_reg = wpbt_pkg::THR_RESET;
  bit                          bond_tab [wpbt_pkg::CONF_SPAN][wpbt_pkg::CONF_SPAN];
  logic [wpbt_pkg::CONF_W-1:0] slot_conf_q [8];
  logic [wpbt_pkg::CNT_W-1:0]  cnt_tab [8][8] = '{default: '0};
  logic [wpbt_pkg::CNT_W-1:0]  total = '0;
  bit [7:0]                    slot_known = '0;  // generator side: slots written since reset

  function automatic int active_n();
    if (act_reg < 2) return 2;
    if (act_reg > 8) return 8;
    return int'(act_reg);
  endfunction

  function automatic logic [wpbt_pkg::CNT_W-1:0] sat_add(logic [wpbt_pkg::CNT_W-1:0] a,
                                                         logic [wpbt_pkg::CNT_W-1:0] b);
    logic [wpbt_pkg::CNT_W:0] s;
    s = {1'b0, a} + b;
    return s[wpbt_pkg::CNT_W] ? wpbt_pkg::SAT32 : s[wpbt_pkg::CNT_W-1:0];
  endfunction

  function automatic void tally_update(tally_item_t it);
    int n;
    int k;
    pair_result_t r;
    longint unsigned c64, t64, q;
    n = active_n();
    k = 0;
    case (it.mode)
      wpbt_pkg::MODE_BOND: bond_tab[it.row][it.col] = it.bond;
      wpbt_pkg::MODE_SLOT: begin
        if (it.slot < n) slot_conf_q[it.slot] = it.sconf;
        if (it.rend) begin
          total = sat_add(total, wpbt_pkg::CNT_W'(it.weight));
          for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
              if (i != j && bond_tab[slot_conf_q[i]][slot_conf_q[j]])
                cnt_tab[i][j] = sat_add(cnt_tab[i][j], wpbt_pkg::CNT_W'(it.weight));
        end
      end
      wpbt_pkg::MODE_REPORT: begin
        for (int i = 0; i < n; i++) begin
          for (int j = 0; j < n; j++) begin
            if (i == j) continue;
            r.from_res = wpbt_pkg::RES_W'(i);
            r.to_res = wpbt_pkg::RES_W'(j);
            r.count = cnt_tab[i][j];
            r.total = total;
            r.frac = '0;
            r.flag = 1'b0;
            if (total != 0) begin
              c64 = cnt_tab[i][j];
              t64 = total;
              q = (c64 << 16) / t64;
              if (q > 65536) q = 65536;
              r.frac = wpbt_pkg::FRAC_W'(q);
              r.flag = (c64 * 64'(wpbt_pkg::PPM_SCALE) >= t64 * 64'(thr_reg));
            end
            r.last = (k + 1 == n * (n - 1));
            pair_reports = {pair_reports, r};
            k++;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        tally_update(drv_item);
        accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (tally_items.size() != 0 && $urandom_range(99) >= send_idle) begin
          drv_item = tally_items.pop_front();
          in_tdata <= {4'b0, drv_item.weight, drv_item.sconf, drv_item.slot,
                       drv_item.bond, drv_item.col, drv_item.row};
          in_tuser <= drv_item.mode;
          in_tlast <= drv_item.rend;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pair_reports.size() == 0) begin
        $error("pair result with nothing pending: from %0d to %0d count %0d",
               out_tdata[2:0], out_tdata[5:3], out_tdata[37:6]);
        mismatches++;
      end else begin
        want = pair_reports.pop_front();
        check_field("from_residue", want.from_res, out_tdata[2:0]);
        check_field("to_residue", want.to_res, out_tdata[5:3]);
        check_field("weighted_count", want.count, out_tdata[37:6]);
        check_field("fraction_q16", want.frac, out_tdata[54:38]);
        check_field("above_threshold", want.flag, out_tdata[55]);
        check_field("total_weight", want.total, out_tdata[87:56]);
        check_field("last", want.last, out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------- stimulus generation ----------------
  function automatic tally_item_t rand_item(logic [1:0] mode);
    tally_item_t it;
    it.mode = mode;
    it.row = wpbt_pkg::CONF_W'($urandom_range(255));
    it.col = wpbt_pkg::CONF_W'($urandom_range(255));
    it.bond = 1'($urandom_range(1));
    it.slot = wpbt_pkg::RES_W'($urandom_range(7));
    it.sconf = wpbt_pkg::CONF_W'($urandom_range(255));
    it.weight = wpbt_pkg::WEIGHT_W'($urandom_range(24'hFFFFFF));
    it.rend = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic void push_item(tally_item_t it);
    tally_items = {tally_items, it};
    queued++;
  endfunction

  function automatic logic [wpbt_pkg::CONF_W-1:0] pool_conf();
    return CONF_POOL[$urandom_range(5)];
  endfunction

  function automatic logic [wpbt_pkg::WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3, 4: return wpbt_pkg::WEIGHT_W'($urandom_range(255));
      default: return wpbt_pkg::WEIGHT_W'($urandom_range(24'hFFFFFF));
    endcase
  endfunction

  function automatic void push_bond(logic [wpbt_pkg::CONF_W-1:0] r,
                                    logic [wpbt_pkg::CONF_W-1:0] c, bit b);
    tally_item_t it;
    it = rand_item(wpbt_pkg::MODE_BOND);
    it.row = r;
    it.col = c;
    it.bond = b;
    push_item(it);
  endfunction

  // a record only closes once every active slot holds a written conformer
  function automatic void push_slot(int s, logic [wpbt_pkg::CONF_W-1:0] c, bit rend,
                                    logic [wpbt_pkg::WEIGHT_W-1:0] w);
    tally_item_t it;
    int n;
    it = rand_item(wpbt_pkg::MODE_SLOT);
    n = active_n();
    it.slot = wpbt_pkg::RES_W'(s);
    it.sconf = c;
    it.weight = w;
    if (s < n) slot_known[s] = 1'b1;
    for (int i = 0; i < n; i++)
      if (!slot_known[i]) rend = 1'b0;
    it.rend = rend;
    push_item(it);
  endfunction

  function automatic void push_other(logic [1:0] mode);
    push_item(rand_item(mode));
  endfunction

  task automatic gen_random(int cnt);
    int start, pick, n, k, tmp;
    int ord [8];
    start = queued;
    while (queued - start < cnt) begin
      pick = $urandom_range(99);
      n = active_n();
      if (pick < 50) begin
        // full record, slots in shuffled order, closing on the last one
        for (int i = 0; i < 8; i++) ord[i] = i;
        for (int i = n - 1; i > 0; i--) begin
          k = $urandom_range(i);
          tmp = ord[i];
          ord[i] = ord[k];
          ord[k] = tmp;
        end
        for (int i = 0; i < n; i++)
          push_slot(ord[i], pool_conf(), i == n - 1, pick_weight());
      end else if (pick < 68) begin
        if ($urandom_range(3) == 0)
          push_bond(wpbt_pkg::CONF_W'($urandom_range(255)),
                    wpbt_pkg::CONF_W'($urandom_range(255)), 1'($urandom_range(1)));
        else
          push_bond(pool_conf(), pool_conf(), 1'($urandom_range(1)));
      end else if (pick < 80) begin
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++)
          push_slot($urandom_range(7), pool_conf(), 1'b0, pick_weight());
      end else if (pick < 90) begin
        push_slot($urandom_range(7), pool_conf(), 1'b1, pick_weight());
      end else if (pick < 97) begin
        push_other(wpbt_pkg::MODE_REPORT);
      end else begin
        push_other(MODE_UNUSED);
      end
    end
    push_other(wpbt_pkg::MODE_REPORT);
  endtask

  // ---------------- register access ----------------
  task automatic reg_write(input logic [wpbt_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [wpbt_pkg::CFG_DATA_W-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_read(input logic [wpbt_pkg::CFG_ADDR_W-1:0] addr,
                          output logic [wpbt_pkg::CFG_DATA_W-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    data = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_regs();
    logic [wpbt_pkg::CFG_DATA_W-1:0] rd;
    reg_read(ADDR_ACTIVE, rd);
    check_field("active_residues readback", act_reg, rd);
    reg_read(ADDR_THRESH, rd);
    check_field("threshold_ppm readback", thr_reg, rd);
  endtask

  task automatic set_config(logic [wpbt_pkg::NRES_W-1:0] act,
                            logic [wpbt_pkg::THR_W-1:0] thr);
    reg_write(ADDR_ACTIVE, wpbt_pkg::CFG_DATA_W'(act));
    reg_write(ADDR_THRESH, wpbt_pkg::CFG_DATA_W'(thr));
    act_reg = act;
    thr_reg = thr;
    check_regs();
  endtask

  task automatic settle();
    while (accepted != queued || pair_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle = 18;
    recv_idle = 73;
    check_regs();

    // every conformer pair that a slot may name gets a known bond bit
    foreach (CONF_POOL[a])
      foreach (CONF_POOL[b])
        push_bond(CONF_POOL[a], CONF_POOL[b], $urandom_range(9) < 6);

    // empty tally first, then an unused mode and extreme weights
    push_other(wpbt_pkg::MODE_REPORT);
    push_other(MODE_UNUSED);
    push_slot(0, 8'd0, 1'b0, '0);
    push_slot(1, 8'd255, 1'b0, '0);
    push_slot(2, 8'd1, 1'b0, '0);
    push_slot(3, 8'd128, 1'b0, '0);
    push_slot(4, 8'd127, 1'b0, '0);
    push_slot(5, 8'd2, 1'b0, '0);
    push_slot(6, 8'd0, 1'b0, '0);
    push_slot(7, 8'd255, 1'b1, '1);
    push_slot(3, 8'd255, 1'b1, '0);
    push_slot(0, 8'd128, 1'b1, 24'd1);
    push_other(wpbt_pkg::MODE_REPORT);
    settle();

    // closing slot outside the active range stores nothing
    set_config(4'd2, '0);
    push_slot(6, 8'hAA, 1'b1, 24'h800000);
    push_other(wpbt_pkg::MODE_REPORT);
    settle();

    set_config(4'd15, 20'd1000000);
    push_other(wpbt_pkg::MODE_REPORT);
    gen_random(RANDOM_ITEMS);
    settle();

    set_config(4'd1, wpbt_pkg::THR_W'($urandom_range(1000000)));
    gen_random(RANDOM_ITEMS);
    settle();

    send_idle = 73;
    recv_idle = 18;
    set_config(wpbt_pkg::NRES_W'($urandom_range(3, 7)),
               wpbt_pkg::THR_W'($urandom_range(1000000)));
    gen_random(RANDOM_ITEMS);
    settle();

    set_config(4'd8, 20'd1000);
    gen_random(RANDOM_ITEMS);
    settle();

    // drive the total and one pair count into saturation
    send_idle = 0;
    recv_idle = 0;
    set_config(4'd2, 20'd500000);
    push_bond(8'd1, 8'd128, 1'b1);
    push_bond(8'd128, 8'd1, 1'b0);
    push_slot(0, 8'd1, 1'b0, '0);
    push_slot(1, 8'd128, 1'b0, '0);
    for (int i = 0; i < SAT_RECORDS; i++)
      push_slot(7, pool_conf(), 1'b1, '1);
    push_other(wpbt_pkg::MODE_REPORT);
    settle();

    set_config(4'd8, 20'd500000);
    push_other(wpbt_pkg::MODE_REPORT);
    settle();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
